@@ rtl/wavetable_channel_regs_timer_unit_assert.svh @@
// assertion macros shared by the wavetable channel rtl
`ifndef WAVETABLE_CHANNEL_REGS_TIMER_UNIT_ASSERT_SVH
`define WAVETABLE_CHANNEL_REGS_TIMER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define WVT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavetable channel assertion failed");

// next-cycle implication, off while reset is low
`define WVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavetable channel assertion failed");

`endif

@@ rtl/wvt_pkg.sv @@
// ----------------------------------------------------------------------------
// wvt_pkg
// Types, register addresses and helper functions of the wavetable channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wvt_pkg;

  // request: a bus write or a batch of clock ticks
  typedef struct packed {
    logic       req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [4:0] tick_count;
  } req_t;

  // result of one request
  typedef struct packed {
    logic [7:0] read_back;
    logic [4:0] position;
    logic [7:0] sample_byte;
    logic [2:0] volume_shift;
    logic [8:0] length_left;
    logic       length_on;
    logic       playing;
    logic       channel_status;
  } rsp_t;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICKS = 1'b1;

  // register addresses
  localparam logic [7:0] ADDR_PLAY    = 8'h1A;
  localparam logic [7:0] ADDR_LENGTH  = 8'h1B;
  localparam logic [7:0] ADDR_VOLUME  = 8'h1C;
  localparam logic [7:0] ADDR_FREQ_LO = 8'h1D;
  localparam logic [7:0] ADDR_FREQ_HI = 8'h1E;
  localparam logic [3:0] WAVE_PAGE    = 4'h3;

  // read-back masks
  localparam logic [7:0] RB_PLAY_MASK   = 8'h7F;
  localparam logic [7:0] RB_VOLUME_MASK = 8'h9F;
  localparam logic [7:0] RB_FREQ_MASK   = 8'hBF;
  localparam logic [7:0] RB_ALL_ONES    = 8'hFF;

  localparam logic [8:0]  LEN_FULL  = 9'd256;
  localparam logic [4:0]  MAX_TICKS = 5'd16;
  localparam logic [15:0] ACC_MAX   = 16'd32784;

  // volume code to sample shift
  function automatic logic [2:0] vol_shift_of(input logic [1:0] code);
    logic [2:0] s;
    case (code)
      2'd0: s = 3'd4;
      2'd1: s = 3'd0;
      2'd2: s = 3'd1;
      2'd3: s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // timer period (2048 - freq) * 16
  function automatic logic [15:0] period_of(input logic [10:0] freq);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, freq};
    return {span, 4'b0000};
  endfunction

endpackage

`default_nettype wire

@@ rtl/wvt_stream_if.sv @@
// ----------------------------------------------------------------------------
// wvt_stream_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wvt_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/wvt_ram.sv @@
// ----------------------------------------------------------------------------
// wvt_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address read and write).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/wavetable_channel_regs_timer_unit.sv @@
// ----------------------------------------------------------------------------
// wavetable_channel_regs_timer_unit
// Wavetable sound channel registers, wave RAM and frequency timer.
// ----------------------------------------------------------------------------
//  channel    dir  payload          meaning
//  in_chan    in   wvt_pkg::req_t   bus write or tick batch
//  out_chan   out  wvt_pkg::rsp_t   read-back and channel state
//
//  One request per cycle while the output is not stalled; its result is
//  registered in stage one (state update and wave RAM read), then in the
//  output register, before it is offered.
//  Throughput is set by the single read port of the wave RAM, used once per
//  request to fetch the sample byte at the new position.
//  Reset: synchronous, active low; 16 valid bits mark written wave bytes,
//  no clearing pass. A stalled output holds the pipeline behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wavetable_channel_regs_timer_unit #(
  parameter int WAVE_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  wvt_stream_if.sink    in_chan,
  wvt_stream_if.source  out_chan
);

  localparam int AW = $clog2(WAVE_BYTES);

  // channel state
  logic            play_r,   play_nxt;
  logic [8:0]      len_r,    len_nxt;
  logic            len_en_r, len_en_nxt;
  logic [2:0]      vol_r,    vol_nxt;
  logic [10:0]     freq_r,   freq_nxt;
  logic [15:0]     acc_r,    acc_nxt;
  logic [4:0]      pos_r,    pos_nxt;
  logic            status_r, status_nxt;
  logic [WAVE_BYTES-1:0] wv_r, wv_nxt;

  // pipeline
  logic            s1_v_r;
  wvt_pkg::rsp_t   s1_rsp_r;
  logic            s1_hit_r;
  logic            s1_sv_r;
  logic [7:0]      s1_fwd_r;
  logic            out_v_r;
  wvt_pkg::rsp_t   out_r;

  logic            in_acc;
  logic            out_free;
  logic            s1_move;
  wvt_pkg::req_t   req;
  logic [7:0]      rb;
  logic [4:0]      n_ticks;
  logic [16:0]     acc_sum;
  logic [15:0]     per_cur;
  logic [15:0]     per_new;
  logic [10:0]     freq_wr;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      sample;
  wvt_pkg::rsp_t   rsp_nxt;
  wvt_pkg::rsp_t   s1_out;
  logic            chk_pos_keep;
  logic            chk_idle_tick;

  assign req      = in_chan.data;
  assign out_free = !out_v_r || out_chan.ready;
  assign s1_move  = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || out_free;
  assign in_acc   = in_chan.valid && in_chan.ready;

  // timer arithmetic
  assign n_ticks = (req.tick_count > wvt_pkg::MAX_TICKS) ? wvt_pkg::MAX_TICKS
                                                          : req.tick_count;
  assign acc_sum = {1'b0, acc_r} + {12'd0, n_ticks};
  assign per_cur = wvt_pkg::period_of(freq_r);

  // frequency as written by a low or high byte write
  always_comb begin
    if (req.reg_addr == wvt_pkg::ADDR_FREQ_LO) begin
      freq_wr = {freq_r[10:8], req.write_data};
    end else begin
      freq_wr = {req.write_data[2:0], freq_r[7:0]};
    end
  end
  assign per_new = wvt_pkg::period_of(freq_wr);

  // request decode and state update
  always_comb begin
    play_nxt   = play_r;
    len_nxt    = len_r;
    len_en_nxt = len_en_r;
    vol_nxt    = vol_r;
    freq_nxt   = freq_r;
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    rb         = 8'd0;
    we         = 1'b0;
    if (in_acc) begin
      if (req.req_type == wvt_pkg::REQ_TICKS) begin
        if (play_r) begin
          if (acc_sum > {1'b0, per_cur}) begin
            acc_nxt = 16'(acc_sum - {1'b0, per_cur});
            pos_nxt = pos_r + 5'd1;
          end else begin
            acc_nxt = acc_sum[15:0];
          end
        end
      end else if (req.reg_addr[7:4] == wvt_pkg::WAVE_PAGE) begin
        we = 1'b1;
      end else begin
        case (req.reg_addr)
          wvt_pkg::ADDR_PLAY: begin
            play_nxt = req.write_data[7];
            rb       = req.write_data | wvt_pkg::RB_PLAY_MASK;
          end
          wvt_pkg::ADDR_LENGTH: begin
            len_nxt = wvt_pkg::LEN_FULL - {1'b0, req.write_data};
            rb      = wvt_pkg::RB_ALL_ONES;
          end
          wvt_pkg::ADDR_VOLUME: begin
            vol_nxt = wvt_pkg::vol_shift_of(req.write_data[6:5]);
            rb      = req.write_data | wvt_pkg::RB_VOLUME_MASK;
          end
          wvt_pkg::ADDR_FREQ_LO: begin
            freq_nxt = freq_wr;
            if (acc_r > per_new) begin
              acc_nxt = 16'd0;
            end
            rb = wvt_pkg::RB_ALL_ONES;
          end
          wvt_pkg::ADDR_FREQ_HI: begin
            if (req.write_data[7]) begin
              len_nxt    = wvt_pkg::LEN_FULL;
              pos_nxt    = 5'd0;
              status_nxt = 1'b1;
            end
            len_en_nxt = req.write_data[6];
            freq_nxt   = freq_wr;
            if (acc_r > per_new) begin
              acc_nxt = 16'd0;
            end
            rb = req.write_data | wvt_pkg::RB_FREQ_MASK;
          end
          default: begin
            rb = 8'd0;
          end
        endcase
      end
    end
  end

  // wave RAM addresses and valid bits
  assign waddr = req.reg_addr[AW-1:0];
  assign raddr = AW'(pos_nxt >> 1);

  always_comb begin
    wv_nxt = wv_r;
    if (we) begin
      wv_nxt[waddr] = 1'b1;
    end
  end

  wvt_ram #(
    .WIDTH (8),
    .DEPTH (WAVE_BYTES)
  ) u_wave_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.write_data),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // result fields known after the update
  always_comb begin
    rsp_nxt                = '0;
    rsp_nxt.read_back      = rb;
    rsp_nxt.position       = pos_nxt;
    rsp_nxt.volume_shift   = vol_nxt;
    rsp_nxt.length_left    = len_nxt;
    rsp_nxt.length_on      = len_en_nxt;
    rsp_nxt.playing        = play_nxt;
    rsp_nxt.channel_status = status_nxt;
  end

  // sample byte: forwarded write, stored byte, or never-written zero
  always_comb begin
    if (s1_hit_r) begin
      sample = s1_fwd_r;
    end else if (s1_sv_r) begin
      sample = ram_rdata;
    end else begin
      sample = 8'd0;
    end
  end

  // stage one result with the sample byte merged in
  always_comb begin
    s1_out             = s1_rsp_r;
    s1_out.sample_byte = sample;
  end

  // control state and channel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r   <= 1'b0;
      len_r    <= 9'd0;
      len_en_r <= 1'b0;
      vol_r    <= 3'd0;
      freq_r   <= 11'd0;
      acc_r    <= 16'd0;
      pos_r    <= 5'd0;
      status_r <= 1'b0;
      wv_r     <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      play_r   <= play_nxt;
      len_r    <= len_nxt;
      len_en_r <= len_en_nxt;
      vol_r    <= vol_nxt;
      freq_r   <= freq_nxt;
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
      wv_r     <= wv_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rsp_r <= rsp_nxt;
      s1_hit_r <= we && (waddr == raddr);
      s1_sv_r  <= wv_r[raddr];
      s1_fwd_r <= req.write_data;
    end
    if (s1_move) begin
      out_r <= s1_out;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  // checks
  assign chk_pos_keep  = in_acc && (req.req_type == wvt_pkg::REQ_WRITE) &&
                         (req.reg_addr != wvt_pkg::ADDR_FREQ_HI);
  assign chk_idle_tick = in_acc && (req.req_type == wvt_pkg::REQ_TICKS) && !play_r;

`include "wavetable_channel_regs_timer_unit_assert.svh"

  `WVT_ASSERT_NEXT(a_pos_hold, clk, rst_n, chk_pos_keep, pos_r == $past(pos_r))
  `WVT_ASSERT_IMPLIES(a_acc_bound, clk, rst_n, 1'b1, acc_r <= wvt_pkg::ACC_MAX)
  `WVT_ASSERT_NEXT(a_idle_ticks, clk, rst_n, chk_idle_tick, acc_r == $past(acc_r))

endmodule

`default_nettype wire
